// ===== rtl/cke_pkg.sv =====
// ----------------------------------------------------------------------------
// cke_pkg: shared types and constants for the ChaCha20 keystream XOR block
// Word and byte types, register index codes, mode constants and the
// quarter-round rotate.
// ----------------------------------------------------------------------------
`default_nettype none

package cke_pkg;

	typedef logic [7:0]  data_t;
	typedef logic [31:0] word_t;

	localparam int REG_IDX_W = 3;
	localparam int REG_W     = 64;

	// Configuration register indexes
	typedef enum logic [REG_IDX_W-1:0] {
		REG_KEY_01     = 3'd0,
		REG_KEY_23     = 3'd1,
		REG_KEY_45     = 3'd2,
		REG_KEY_67     = 3'd3,
		REG_KEY_IS_256 = 3'd4,
		REG_CTR_NONCE  = 3'd5,
		REG_NONCE_HI   = 3'd6
	} reg_idx_t;

	// "expand 32-byte k" and "expand 16-byte k"
	localparam word_t SIGMA_WIDE [4]   = '{32'h61707865, 32'h3320646e,
		32'h79622d32, 32'h6b206574};
	localparam word_t SIGMA_NARROW [4] = '{32'h61707865, 32'h3120646e,
		32'h79622d36, 32'h6b206574};

	// Rotate for each of the four lines of a quarter-round: 16, 12, 8, 7
	function automatic word_t qr_rotl(word_t v, logic [1:0] line);
		word_t r;
		case (line)
			2'd0:    r = {v[15:0], v[31:16]};
			2'd1:    r = {v[19:0], v[31:20]};
			2'd2:    r = {v[23:0], v[31:24]};
			default: r = {v[24:0], v[31:25]};
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/cke_ifs.sv =====
// ----------------------------------------------------------------------------
// cke_ifs: request channels of the ChaCha20 keystream XOR block
// Input channel (data byte and message start) and result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface cke_item_if;
	import cke_pkg::*;
	logic  valid;
	logic  ready;
	data_t data_byte;
	logic  starts_message;
	modport source (output valid, data_byte, starts_message, input ready);
	modport sink   (input valid, data_byte, starts_message, output ready);
endinterface

interface cke_result_if;
	import cke_pkg::*;
	logic  valid;
	logic  ready;
	data_t out_byte;
	modport source (output valid, out_byte, input ready);
	modport sink   (input valid, out_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/chacha20_keystream_xor_top.sv =====
// ----------------------------------------------------------------------------
// chacha20_keystream_xor_top: ChaCha20 keystream XOR, one byte per request
// Flow: a byte inside the current block shows on the result in the cycle
//   after it is taken. A byte that needs a fresh block waits for the rounds,
//   run one line of a quarter-round per cycle on a single add/xor/rotate
//   unit, and for the feed-forward of all 16 words through the same adder;
//   its result then goes to the output register.
// Throughput: one byte per cycle within a block while the result is not
//   stalled; no byte is taken while a fresh block is being made.
// Reset (arst_n low): key and nonce cleared, 256-bit key mode, block counter
//   zero, no block held, so the first byte always makes a block.
// ----------------------------------------------------------------------------
`default_nettype none

module chacha20_keystream_xor_top #(
	parameter int ROUND_COUNT = 20
) (
	input  logic                          clk,
	input  logic                          arst_n,
	cke_item_if.sink                      item,
	cke_result_if.source                  result,
	input  logic                          wr_en,
	input  logic [cke_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [cke_pkg::REG_W-1:0]     wr_data
);
	import cke_pkg::*;

	// An odd round count rounds up to whole double rounds
	localparam int DROUNDS = (ROUND_COUNT + 1) / 2;
	localparam int DR_W    = (DROUNDS > 1) ? $clog2(DROUNDS) : 1;
	localparam logic [DR_W-1:0] DR_LAST = DR_W'(DROUNDS - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_ROUND,
		S_FEED,
		S_EMIT
	} fsm_t;

	fsm_t fsm_q;

	// Configuration
	logic [63:0] key01_q, key23_q, key45_q, key67_q, nonce_hi_q;
	logic        key_is_256_q;
	logic [63:0] blk_ctr_q;

	// Sequencer
	logic [1:0]      line_q;     // line within a quarter-round
	logic [2:0]      quarter_q;  // bit 2 set: diagonal half of the double round
	logic [DR_W-1:0] dr_q;
	logic [3:0]      ff_q;       // feed-forward word
	logic [6:0]      pos_q;      // bytes used of the current block, 0..64

	// Payload
	word_t st_q [16];            // working state, then the keystream block
	data_t data_q;
	data_t out_byte_q;
	logic  out_vld_q;

	word_t init_w [16];
	word_t upd_w [16];
	word_t rot_w [16];
	logic  diag;
	word_t tb, tc, td;
	word_t add_x, add_y, add_sum, mixed, mix_src;
	word_t ks_word;
	data_t ks_byte;
	logic  take, need_blk, out_free, emit_go;

	// ---------------------------------------------------------------- init state
	// Words 0-3 constants, 4-11 key (128-bit key repeated), 12-13 counter,
	// 14-15 nonce.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			init_w[i] = key_is_256_q ? SIGMA_WIDE[i] : SIGMA_NARROW[i];
		end
		init_w[4]  = key01_q[31:0];
		init_w[5]  = key01_q[63:32];
		init_w[6]  = key23_q[31:0];
		init_w[7]  = key23_q[63:32];
		init_w[8]  = key_is_256_q ? key45_q[31:0]  : key01_q[31:0];
		init_w[9]  = key_is_256_q ? key45_q[63:32] : key01_q[63:32];
		init_w[10] = key_is_256_q ? key67_q[31:0]  : key23_q[31:0];
		init_w[11] = key_is_256_q ? key67_q[63:32] : key23_q[63:32];
		init_w[12] = blk_ctr_q[31:0];
		init_w[13] = blk_ctr_q[63:32];
		init_w[14] = nonce_hi_q[31:0];
		init_w[15] = nonce_hi_q[63:32];
	end

	// ---------------------------------------------------------------- shared unit
	// The unit always works on fixed taps: words 0,4,8,12 for a column and
	// 0,5,10,15 for a diagonal. After each quarter-round every row of four
	// words is rotated left by one, bringing the next column or diagonal
	// onto the taps; four rotations restore the original layout.
	assign diag = quarter_q[2];
	assign tb   = diag ? st_q[5]  : st_q[4];
	assign tc   = diag ? st_q[10] : st_q[8];
	assign td   = diag ? st_q[15] : st_q[12];

	// Even lines: a += b, d = (d ^ a) <<< s. Odd lines: c += d, b = (b ^ c) <<< s.
	// In feed-forward the adder sums word 0 with its initial word.
	always_comb begin
		if (fsm_q == S_FEED) begin
			add_x = st_q[0];
			add_y = init_w[ff_q];
		end else if (!line_q[0]) begin
			add_x = st_q[0];
			add_y = tb;
		end else begin
			add_x = tc;
			add_y = td;
		end
	end

	assign add_sum = add_x + add_y;
	assign mix_src = line_q[0] ? tb : td;
	assign mixed   = qr_rotl(mix_src ^ add_sum, line_q);

	always_comb begin
		upd_w = st_q;
		if (!line_q[0]) begin
			upd_w[0] = add_sum;
			if (diag) begin
				upd_w[15] = mixed;
			end else begin
				upd_w[12] = mixed;
			end
		end else begin
			if (diag) begin
				upd_w[10] = add_sum;
				upd_w[5]  = mixed;
			end else begin
				upd_w[8] = add_sum;
				upd_w[4] = mixed;
			end
		end
		for (int r = 0; r < 4; r++) begin
			for (int j = 0; j < 4; j++) begin
				rot_w[4*r + j] = upd_w[4*r + ((j + 1) % 4)];
			end
		end
	end

	// ---------------------------------------------------------------- handshake
	assign out_free   = !out_vld_q || result.ready;
	assign item.ready = (fsm_q == S_IDLE) && out_free;
	assign take       = item.valid && item.ready;
	// A fresh block on a message start, with no block yet, or once 64 bytes used
	assign need_blk   = item.starts_message || (pos_q == 7'd0) || pos_q[6];
	assign emit_go    = (fsm_q == S_EMIT) && out_free;

	// Keystream byte p is byte p%4 of word p/4
	assign ks_word = st_q[pos_q[5:2]];
	assign ks_byte = ks_word[{pos_q[1:0], 3'b000} +: 8];

	assign result.valid    = out_vld_q;
	assign result.out_byte = out_byte_q;

	// ---------------------------------------------------------------- control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q        <= S_IDLE;
			line_q       <= '0;
			quarter_q    <= '0;
			dr_q         <= '0;
			ff_q         <= '0;
			pos_q        <= '0;
			out_vld_q    <= 1'b0;
			key01_q      <= '0;
			key23_q      <= '0;
			key45_q      <= '0;
			key67_q      <= '0;
			key_is_256_q <= 1'b1;
			blk_ctr_q    <= '0;
			nonce_hi_q   <= '0;
		end else begin
			// Loaded by an in-block byte or an emitted block byte, held while stalled
			out_vld_q <= (take && !need_blk) || emit_go || (out_vld_q && !result.ready);
			unique case (fsm_q)
				S_IDLE: begin
					if (take) begin
						if (need_blk) begin
							line_q    <= '0;
							quarter_q <= '0;
							dr_q      <= '0;
							fsm_q     <= S_ROUND;
						end else begin
							pos_q     <= pos_q + 7'd1;
						end
					end
				end
				S_ROUND: begin
					line_q <= line_q + 2'd1;
					if (line_q == 2'd3) begin
						quarter_q <= quarter_q + 3'd1;
						if (quarter_q == 3'd7) begin
							dr_q <= dr_q + DR_W'(1);
							if (dr_q == DR_LAST) begin
								ff_q  <= '0;
								fsm_q <= S_FEED;
							end
						end
					end
				end
				S_FEED: begin
					ff_q <= ff_q + 4'd1;
					if (ff_q == 4'd15) begin
						blk_ctr_q <= blk_ctr_q + 64'd1;
						fsm_q     <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						pos_q     <= 7'd1;
						fsm_q     <= S_IDLE;
					end
				end
				default: fsm_q <= S_IDLE;
			endcase
			// Writes must arrive only while idle; the block itself does not enforce it
			if (wr_en) begin
				unique case (wr_index)
					REG_KEY_01:     key01_q      <= wr_data;
					REG_KEY_23:     key23_q      <= wr_data;
					REG_KEY_45:     key45_q      <= wr_data;
					REG_KEY_67:     key67_q      <= wr_data;
					REG_KEY_IS_256: key_is_256_q <= wr_data[0];
					REG_CTR_NONCE:  blk_ctr_q    <= wr_data;
					REG_NONCE_HI:   nonce_hi_q   <= wr_data;
					default: ;
				endcase
			end
		end
	end

	// ---------------------------------------------------------------- datapath
	always_ff @(posedge clk) begin
		case (fsm_q)
			S_IDLE: begin
				if (take) begin
					if (need_blk) begin
						st_q   <= init_w;
						data_q <= item.data_byte;
					end else begin
						out_byte_q <= item.data_byte ^ ks_byte;
					end
				end
			end
			S_ROUND: begin
				st_q <= (line_q == 2'd3) ? rot_w : upd_w;
			end
			S_FEED: begin
				// Shift down one word; the finished word enters at the top
				for (int i = 0; i < 15; i++) begin
					st_q[i] <= st_q[i + 1];
				end
				st_q[15] <= add_sum;
			end
			S_EMIT: begin
				if (emit_go) begin
					out_byte_q <= data_q ^ st_q[0][7:0];
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/cke_checker.sv =====
// ----------------------------------------------------------------------------
// cke_port_checks: port checks for the ChaCha20 keystream XOR block
// Watches the request channels of the top level; bound in below.
// ----------------------------------------------------------------------------
`default_nettype none

module cke_port_checks (
	input wire       clk,
	input wire       arst_n,
	input wire       item_valid,
	input wire       item_ready,
	input wire       result_valid,
	input wire       result_ready,
	input wire [7:0] result_byte
);

	// Stalled result holds its valid
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result valid dropped while stalled");

	// Stalled result holds its byte
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(result_byte))
		else $error("result byte changed while stalled");

	// One byte in flight at most: no new request while a result is stuck
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |-> !item_ready)
		else $error("input taken while result stalled");

	// A result appears only after a request was taken or while busy
	a_res_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_valid && item_ready) || $past(!item_ready))
		else $error("result without a request");

endmodule

bind chacha20_keystream_xor_top cke_port_checks u_cke_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_byte  (result.out_byte)
);

`default_nettype wire
